### hdl/dwc_pkg.sv
package dwc_pkg;
  typedef enum logic [1:0] {
    MODE_SAMPLE = 2'd0,
    MODE_WEIGHT = 2'd1,
    MODE_BIAS   = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_ROWS  = 3'd0,
    REG_COLS  = 3'd1,
    REG_CHANS = 3'd2,
    REG_RELU  = 3'd3,
    REG_SHIFT = 3'd4
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_MAC,
    ST_SHAPE,
    ST_OUT
  } state_t;

  localparam int TAPS = 9;
  localparam int OUT_BITS = 16;
  localparam int ACC_BITS = 64;
endpackage

### hdl/dwc_if.sv
interface dwc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [3:0]  tap;
  logic [5:0]  lane;
  logic signed [31:0] value;
  modport source (output valid, mode, tap, lane, value, input ready);
  modport sink (input valid, mode, tap, lane, value, output ready);
endinterface

interface dwc_out_if;
  logic        valid;
  logic        ready;
  logic [6:0]  out_row;
  logic [6:0]  out_col;
  logic [5:0]  out_channel;
  logic signed [15:0] out_value;
  logic        last_of_run;
  modport source (output valid, out_row, out_col, out_channel, out_value, last_of_run,
                  input ready);
  modport sink (input valid, out_row, out_col, out_channel, out_value, last_of_run,
                output ready);
endinterface

interface dwc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### hdl/dwc_mem.sv
module dwc_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

### hdl/depthwise_conv_3x3_relu_top.sv
// Depthwise 3x3 convolution, stride 1, zero-padded same-size output, with
// per-channel bias, optional ReLU, shift and 16-bit saturation.
// Channels: in (mode/tap/lane/value), out (row/col/channel/value/last_of_run),
// cfg (index/data). Modes: sample, weight load, bias load.
// A sample completes 0 to 4 outputs. Each output takes nine reads of the
// line and weight memories through one shared multiply-accumulate, set by
// the single read port of each memory, then a shape stage and the output
// register. Typical interior samples emit one output.
// The input stays not-ready while a sample's outputs are computed or wait.
// A stalled receiver holds the output register; nothing is lost.
// Reset clears position counters and registers (rows 1, cols 1, 64
// channels, ReLU off, shift 0). Memories are not cleared; reading weights,
// bias or line entries never written gives undefined values.
// Writes to rows, cols or channels restart the frame; cfg is taken when idle.
module depthwise_conv_3x3_relu_top
  import dwc_pkg::*;
#(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128,
  parameter int MAX_CHANNELS = 64,
  parameter int SAMPLE_BITS = 16
) (
  input logic clk,
  input logic rst,
  dwc_in_if.sink   in_ch,
  dwc_out_if.source out_ch,
  dwc_cfg_if.sink  cfg
);
  localparam int CW = $clog2(MAX_COLS) > 0 ? $clog2(MAX_COLS) : 1;
  localparam int RW = $clog2(MAX_ROWS) > 0 ? $clog2(MAX_ROWS) : 1;
  localparam int HW = $clog2(MAX_CHANNELS) > 0 ? $clog2(MAX_CHANNELS) : 1;
  localparam int LDEPTH = 3 * MAX_COLS * MAX_CHANNELS;
  localparam int LAW = $clog2(LDEPTH);
  localparam int WDEPTH = TAPS * MAX_CHANNELS;
  localparam int WAW = $clog2(WDEPTH);
  localparam int BAW = HW;
  localparam logic signed [31:0] SMAX = 32'sd2 ** (SAMPLE_BITS - 1) - 1;
  localparam logic signed [31:0] SMIN = -SMAX - 1;

  logic [7:0] frame_rows, frame_cols;
  logic [6:0] channel_count;
  logic relu_enable;
  logic [4:0] out_shift;
  logic [RW:0] rows_eff;
  logic [CW:0] cols_eff;
  logic [HW:0] chans_eff;

  always_comb begin
    rows_eff = (frame_rows == 8'd0) ? (RW+1)'(1) :
               (32'(frame_rows) > MAX_ROWS) ? (RW+1)'(MAX_ROWS) : (RW+1)'(frame_rows);
    cols_eff = (frame_cols == 8'd0) ? (CW+1)'(1) :
               (32'(frame_cols) > MAX_COLS) ? (CW+1)'(MAX_COLS) : (CW+1)'(frame_cols);
    chans_eff = (channel_count == 7'd0) ? (HW+1)'(1) :
                (32'(channel_count) > MAX_CHANNELS) ? (HW+1)'(MAX_CHANNELS) :
                (HW+1)'(channel_count);
  end

  state_t state, state_next;
  logic [RW:0] row_cnt;
  logic [CW:0] col_cnt;
  logic [HW:0] chan_cnt;
  logic [1:0] r3_cnt;
  logic [RW-1:0] r_cur;
  logic [CW-1:0] c_cur;
  logic [HW-1:0] ch_cur;
  logic [1:0] r3_cur;
  logic r_has_prev, r_is_last, c_has_prev, c_is_last;
  logic [1:0] out_idx;
  logic [3:0] tap_idx;
  logic mac_pending;
  logic [3:0] rd_tap;
  logic rd_ok;
  logic signed [ACC_BITS-1:0] acc;
  logic [RW-1:0] o_row;
  logic [CW-1:0] o_col;
  logic o_rsel;
  logic signed [15:0] res;

  // Sample saturation and load decode
  logic signed [31:0] sat_v;
  logic [SAMPLE_BITS-1:0] sat_s;
  always_comb begin
    sat_v = (in_ch.value > SMAX) ? SMAX : (in_ch.value < SMIN) ? SMIN : in_ch.value;
    sat_s = sat_v[SAMPLE_BITS-1:0];
  end

  logic in_xfer;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign cfg.ready = (state == ST_IDLE);

  // Position with wrap if shape shrank
  logic pos_bad;
  logic [RW:0] row_use;
  logic [CW:0] col_use;
  logic [HW:0] chan_use;
  always_comb begin
    pos_bad = (row_cnt >= rows_eff) || (col_cnt >= cols_eff) || (chan_cnt >= chans_eff);
    row_use = pos_bad ? '0 : row_cnt;
    col_use = pos_bad ? '0 : col_cnt;
    chan_use = pos_bad ? '0 : chan_cnt;
  end

  // Memories
  logic l_we, w_we, b_we;
  logic [LAW-1:0] l_waddr, l_raddr;
  logic [WAW-1:0] w_waddr, w_raddr;
  logic [SAMPLE_BITS-1:0] l_rdata, w_rdata;
  logic [31:0] b_rdata;
  logic [1:0] r3_in;

  // row index mod 3 tracked beside the row counter
  assign r3_in = pos_bad ? 2'd0 : r3_cnt;
  assign l_we = in_xfer && (in_ch.mode == MODE_SAMPLE);
  assign l_waddr = LAW'((32'(r3_in) * MAX_COLS + 32'(col_use)) * MAX_CHANNELS
                        + 32'(chan_use));
  assign w_we = in_xfer && (in_ch.mode == MODE_WEIGHT) && (in_ch.tap < 4'(TAPS))
                && (32'(in_ch.lane) < MAX_CHANNELS);
  assign w_waddr = WAW'(32'(in_ch.tap) * MAX_CHANNELS + 32'(in_ch.lane));
  assign b_we = in_xfer && (in_ch.mode == MODE_BIAS) && (32'(in_ch.lane) < MAX_CHANNELS);

  // Tap address for current output
  logic signed [RW+1:0] ir;
  logic signed [CW+1:0] ic;
  logic [1:0] ir3;
  logic [1:0] tap_r, tap_c;
  logic [2:0] ir3_sum;
  always_comb begin
    tap_r = (rd_tap >= 4'd6) ? 2'd2 : (rd_tap >= 4'd3) ? 2'd1 : 2'd0;
    tap_c = 2'(rd_tap - 4'(tap_r) * 4'd3);
    ir = $signed({2'b00, o_row}) + $signed((RW+2)'(tap_r)) - (RW+2)'(1);
    ic = $signed({2'b00, o_col}) + $signed((CW+2)'(tap_c)) - (CW+2)'(1);
    ir3_sum = 3'(r3_cur) + 3'(tap_r) + 3'd2 - 3'(o_rsel);
    ir3 = (ir3_sum >= 3'd6) ? 2'(ir3_sum - 3'd6) :
          (ir3_sum >= 3'd3) ? 2'(ir3_sum - 3'd3) : 2'(ir3_sum);
    rd_ok = (ir >= 0) && (ic >= 0) && (ir < $signed({1'b0, rows_eff}))
            && (ic < $signed({1'b0, cols_eff}));
    l_raddr = LAW'((32'(ir3) * MAX_COLS + 32'(ic[CW-1:0])) * MAX_CHANNELS + 32'(ch_cur));
    w_raddr = WAW'(32'(rd_tap) * MAX_CHANNELS + 32'(ch_cur));
  end

  dwc_mem #(.DEPTH(LDEPTH), .WIDTH(SAMPLE_BITS)) u_line (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(sat_s), .raddr(l_raddr), .rdata(l_rdata));
  dwc_mem #(.DEPTH(WDEPTH), .WIDTH(SAMPLE_BITS)) u_wgt (
    .clk, .we(w_we), .waddr(w_waddr), .wdata(sat_s), .raddr(w_raddr), .rdata(w_rdata));
  dwc_mem #(.DEPTH(MAX_CHANNELS), .WIDTH(32)) u_bias (
    .clk, .we(b_we), .waddr(in_ch.lane[BAW-1:0]), .wdata(in_ch.value),
    .raddr(ch_cur), .rdata(b_rdata));

  // Output list: out_idx bit1 = row choice, bit0 = col choice
  logic [1:0] nr, nc;
  logic sel_ok;
  always_comb begin
    nr = 2'(r_has_prev) + 2'(r_is_last);
    nc = 2'(c_has_prev) + 2'(c_is_last);
    sel_ok = (out_idx[1] ? (nr == 2'd2) : (nr != 2'd0))
             && (out_idx[0] ? (nc == 2'd2) : (nc != 2'd0));
  end

  // Product register between multiply and accumulate
  logic signed [2*SAMPLE_BITS-1:0] prod;
  logic prod_vld, prod_ok;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  logic out_done;
  assign out_done = out_ch.valid && out_ch.ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_xfer && in_ch.mode == MODE_SAMPLE) state_next = ST_SETUP;
      ST_SETUP: state_next = sel_ok ? ST_MAC : (out_idx == 2'd3 ? ST_IDLE : ST_SETUP);
      ST_MAC:   if (tap_idx == 4'(TAPS + 1)) state_next = ST_SHAPE;
      ST_SHAPE: state_next = ST_OUT;
      ST_OUT:   if (out_done) state_next = (out_idx == 2'd3) ? ST_IDLE : ST_SETUP;
      default:  state_next = ST_IDLE;
    endcase
  end

  // Shaping
  logic signed [ACC_BITS-1:0] sh;
  always_comb begin
    sh = acc >>> out_shift;
    if (acc[ACC_BITS-1] && relu_enable) res = '0;
    else if (sh > 64'sd32767) res = 16'sh7fff;
    else if (sh < -64'sd32768) res = -16'sh8000;
    else res = sh[15:0];
  end

  logic last_next;
  always_comb begin
    last_next = 1'b1;
    for (int k = 0; k < 4; k++)
      if (k > 32'(out_idx) && (k[1] ? (nr == 2'd2) : (nr != 2'd0))
          && (k[0] ? (nc == 2'd2) : (nc != 2'd0)))
        last_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_rows <= 8'd1;
      frame_cols <= 8'd1;
      channel_count <= 7'd64;
      relu_enable <= 1'b0;
      out_shift <= 5'd0;
      row_cnt <= '0;
      col_cnt <= '0;
      chan_cnt <= '0;
      r3_cnt <= 2'd0;
      out_ch.valid <= 1'b0;
      out_idx <= '0;
      tap_idx <= '0;
      prod_vld <= 1'b0;
      mac_pending <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_ROWS:  frame_rows <= cfg.data[7:0];
          REG_COLS:  frame_cols <= cfg.data[7:0];
          REG_CHANS: channel_count <= cfg.data[6:0];
          REG_RELU:  relu_enable <= cfg.data[0];
          REG_SHIFT: out_shift <= cfg.data[4:0];
          default: ;
        endcase
        if (cfg.index == REG_ROWS || cfg.index == REG_COLS || cfg.index == REG_CHANS) begin
          row_cnt <= '0;
          col_cnt <= '0;
          chan_cnt <= '0;
          r3_cnt <= 2'd0;
        end
      end
      if (in_xfer && in_ch.mode == MODE_SAMPLE) begin
        r_cur <= row_use[RW-1:0];
        c_cur <= col_use[CW-1:0];
        ch_cur <= chan_use[HW-1:0];
        r3_cur <= r3_in;
        r_has_prev <= row_use != '0;
        r_is_last <= row_use + 1'b1 == rows_eff;
        c_has_prev <= col_use != '0;
        c_is_last <= col_use + 1'b1 == cols_eff;
        out_idx <= '0;
        if (chan_use + 1'b1 >= chans_eff) begin
          chan_cnt <= '0;
          if (col_use + 1'b1 >= cols_eff) begin
            col_cnt <= '0;
            if (row_use + 1'b1 >= rows_eff) begin
              row_cnt <= '0;
              r3_cnt <= 2'd0;
            end else begin
              row_cnt <= row_use + 1'b1;
              r3_cnt <= (r3_in == 2'd2) ? 2'd0 : r3_in + 2'd1;
            end
          end else begin
            col_cnt <= col_use + 1'b1;
            row_cnt <= row_use;
            r3_cnt <= r3_in;
          end
        end else begin
          chan_cnt <= chan_use + 1'b1;
          col_cnt <= col_use;
          row_cnt <= row_use;
          r3_cnt <= r3_in;
        end
      end
      if (state == ST_SETUP) begin
        tap_idx <= '0;
        prod_vld <= 1'b0;
        mac_pending <= 1'b0;
        if (!sel_ok && out_idx != 2'd3) out_idx <= out_idx + 2'd1;
      end
      if (state == ST_MAC) begin
        tap_idx <= tap_idx + 4'd1;
        mac_pending <= (tap_idx < 4'(TAPS)) && rd_ok;
        prod_vld <= mac_pending;
        prod <= $signed(l_rdata) * $signed(w_rdata);
        if (tap_idx == 4'd1) acc <= ACC_BITS'($signed(b_rdata));
        if (prod_vld) acc <= acc + ACC_BITS'(prod) +
                            ((tap_idx == 4'd1) ? ACC_BITS'($signed(b_rdata)) : '0);
      end
      if (state == ST_SHAPE) begin
        if (prod_vld) acc <= acc + ACC_BITS'(prod);
      end
      if (state == ST_OUT && !out_ch.valid) begin
        out_ch.valid <= 1'b1;
        out_ch.out_row <= 7'(o_row);
        out_ch.out_col <= 7'(o_col);
        out_ch.out_channel <= 6'(ch_cur);
        out_ch.out_value <= res;
        out_ch.last_of_run <= last_next;
      end
      if (out_done) begin
        out_ch.valid <= 1'b0;
        if (out_idx != 2'd3) out_idx <= out_idx + 2'd1;
      end
    end
  end

  // rd_tap is the tap being addressed this MAC cycle
  assign rd_tap = (state == ST_MAC && tap_idx < 4'(TAPS)) ? tap_idx : 4'd0;

  always_comb begin
    o_row = out_idx[1] ? r_cur : ((nr == 2'd2 || r_has_prev) ? r_cur - 1'b1 : r_cur);
    o_col = out_idx[0] ? c_cur : ((nc == 2'd2 || c_has_prev) ? c_cur - 1'b1 : c_cur);
    o_rsel = !out_idx[1] && r_has_prev;
  end

  a_ready_busy: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ch.ready) else $error("ready while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.ready) |=> out_ch.valid && $stable(out_ch.out_value))
    else $error("output dropped");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (chan_cnt <= (HW+1)'(MAX_CHANNELS))) else $error("chan range");
endmodule
